FILE: rtl/rma_pkg.sv
// ----------------------------------------------------------------------------
// rma_pkg
// Shared types, constants and the modular reduction step of the Redcode
// modular arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rma_pkg;

   localparam int CORE_WIDTH = 16;
   localparam logic [CORE_WIDTH-1:0] CORE_SIZE_RESET = 16'd8000;
   localparam int OUT_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      MOD_A  = 3'd0,
      MOD_B  = 3'd1,
      MOD_AB = 3'd2,
      MOD_BA = 3'd3,
      MOD_F  = 3'd4,
      MOD_I  = 3'd5,
      MOD_X  = 3'd6
   } modifier_type;

   // one restoring step: shift in a bit, subtract the modulus once if needed
   function automatic logic [CORE_WIDTH-1:0] mod_step(
      input logic [CORE_WIDTH-1:0] rem,
      input logic                  din,
      input logic [CORE_WIDTH-1:0] m
   );
      logic [CORE_WIDTH:0] acc;
      acc = {rem, din};
      if (acc >= {1'b0, m}) begin
         acc = acc - {1'b0, m};
      end
      return acc[CORE_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rma_if.sv
// ----------------------------------------------------------------------------
// rma_if
// Valid/ready channels of the Redcode modular arithmetic unit: request,
// response and core size write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rma_req_if #(
   parameter int FIELD_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   logic [2:0]             modifier;
   logic [FIELD_WIDTH-1:0] src_a_field;
   logic [FIELD_WIDTH-1:0] src_b_field;
   logic [FIELD_WIDTH-1:0] dst_a_field;
   logic [FIELD_WIDTH-1:0] dst_b_field;
   logic [FIELD_WIDTH-1:0] pc;

   modport source (
      output valid, output req_type, output modifier, output src_a_field,
      output src_b_field, output dst_a_field, output dst_b_field, output pc,
      input ready
   );
   modport sink (
      input valid, input req_type, input modifier, input src_a_field,
      input src_b_field, input dst_a_field, input dst_b_field, input pc,
      output ready
   );
endinterface

interface rma_rsp_if #(
   parameter int FIELD_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] new_a_field;
   logic [FIELD_WIDTH-1:0] new_b_field;
   logic [FIELD_WIDTH-1:0] next_pc;

   modport source (
      output valid, output new_a_field, output new_b_field, output next_pc,
      input ready
   );
   modport sink (
      input valid, input new_a_field, input new_b_field, input next_pc,
      output ready
   );
endinterface

interface rma_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rma_pkg::CORE_WIDTH-1:0]  core_size;

   modport source (output valid, output core_size, input ready);
   modport sink (input valid, input core_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/redcode_modular_arith_unit_top.sv
// ----------------------------------------------------------------------------
// redcode_modular_arith_unit_top
// ADD, SUB and MUL of a Redcode core on prefetched fields, modulo core size,
// as a restoring-reduction pipeline with a two-entry output buffer.
// ----------------------------------------------------------------------------
// Stages: one reduction stage per field bit, one combine stage for ADD,
//   SUB and MUL, 32 product reduction stages, then the output buffer.
// Throughput: one item per cycle; stages stall together when the output
//   buffer is full.
// Reset: valid bits and output buffer cleared, core size set to 8000.
`default_nettype none

module redcode_modular_arith_unit_top #(
   parameter int FIELD_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rma_req_if.sink   req_ch,
   rma_rsp_if.source rsp_ch,
   rma_csr_if.sink   csr_ch
);

   localparam int CW   = rma_pkg::CORE_WIDTH;
   localparam int PW   = 2 * CW;
   localparam int NL   = 5;
   localparam int L_SA = 0;
   localparam int L_SB = 1;
   localparam int L_TA = 2;
   localparam int L_TB = 3;
   localparam int L_PC = 4;
   localparam int RL   = FIELD_WIDTH - 1;
   localparam int PL   = PW - 1;
   localparam int OD   = rma_pkg::OUT_DEPTH;
   localparam int OPW  = $clog2(OD);
   localparam int OCW  = $clog2(OD + 1);

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] new_a;
      logic [FIELD_WIDTH-1:0] new_b;
      logic [FIELD_WIDTH-1:0] npc;
   } out_item_type;

   function automatic logic [PW-1:0] lane_value(
      input logic [1:0]    op,
      input logic          wr,
      input logic [CW-1:0] t,
      input logic [CW-1:0] s,
      input logic [CW-1:0] m
   );
      logic [PW-1:0] val;
      val = PW'(t);
      if (wr) begin
         case (op)
            rma_pkg::OP_ADD: val = PW'(t) + PW'(s);
            rma_pkg::OP_SUB: val = PW'(t) + PW'(m) - PW'(s);
            rma_pkg::OP_MUL: val = PW'(t) * PW'(s);
            default:         val = PW'(t);
         endcase
      end
      return val;
   endfunction

   // ---------------------------------------------------------------- config
   logic [CW-1:0] modulus_ff, modulus_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         modulus_in = (csr_ch.core_size == '0) ? CW'(1) : csr_ch.core_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= rma_pkg::CORE_SIZE_RESET;
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   // ---------------------------------------------------------------- control
   logic           adv;
   logic [OCW-1:0] ob_count_ff, ob_count_in;

   assign adv          = (ob_count_ff < OCW'(OD));
   assign req_ch.ready = adv;

   // ------------------------------------------------------ operand reduction
   logic                   rd_vld_ff  [FIELD_WIDTH];
   logic [1:0]             rd_op_ff   [FIELD_WIDTH];
   logic [2:0]             rd_mod_ff  [FIELD_WIDTH];
   logic [CW-1:0]          rd_rem_ff  [FIELD_WIDTH][NL];
   logic [FIELD_WIDTH-1:0] rd_bits_ff [FIELD_WIDTH][NL];

   for (genvar k = 0; k < FIELD_WIDTH; k++) begin : g_rd
      logic                   vld_src;
      logic [1:0]             op_src;
      logic [2:0]             mod_src;
      logic [CW-1:0]          rem_src  [NL];
      logic [FIELD_WIDTH-1:0] bits_src [NL];
      logic [CW-1:0]          rem_in   [NL];
      logic [FIELD_WIDTH-1:0] bits_in  [NL];

      if (k == 0) begin : g_head
         always_comb begin
            vld_src        = req_ch.valid;
            op_src         = req_ch.req_type;
            mod_src        = req_ch.modifier;
            rem_src[L_SA]  = '0;
            rem_src[L_SB]  = '0;
            rem_src[L_TA]  = '0;
            rem_src[L_TB]  = '0;
            rem_src[L_PC]  = '0;
            bits_src[L_SA] = req_ch.src_a_field;
            bits_src[L_SB] = req_ch.src_b_field;
            bits_src[L_TA] = req_ch.dst_a_field;
            bits_src[L_TB] = req_ch.dst_b_field;
            bits_src[L_PC] = req_ch.pc;
         end
      end else begin : g_body
         always_comb begin
            vld_src = rd_vld_ff[k-1];
            op_src  = rd_op_ff[k-1];
            mod_src = rd_mod_ff[k-1];
            for (int l = 0; l < NL; l++) begin
               rem_src[l]  = rd_rem_ff[k-1][l];
               bits_src[l] = rd_bits_ff[k-1][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < NL; l++) begin
            rem_in[l]  = rma_pkg::mod_step(rem_src[l], bits_src[l][FIELD_WIDTH-1],
                                           modulus_ff);
            bits_in[l] = bits_src[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rd_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            rd_vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rd_op_ff[k]  <= op_src;
            rd_mod_ff[k] <= mod_src;
            for (int l = 0; l < NL; l++) begin
               rd_rem_ff[k][l]  <= rem_in[l];
               rd_bits_ff[k][l] <= bits_in[l];
            end
         end
      end
   end

   // ---------------------------------------------------------- combine stage
   logic [CW-1:0] sa, sb, ta, tb, pc_r;
   logic [CW-1:0] a_src, b_src;
   logic          wr_a, wr_b;
   logic [CW:0]   pc_inc;
   logic          cp_vld_ff;
   logic [PW-1:0] cp_x_ff [2];
   logic [PW-1:0] cp_x_in [2];
   logic [CW-1:0] cp_pc_ff, cp_pc_in;

   assign sa   = rd_rem_ff[RL][L_SA];
   assign sb   = rd_rem_ff[RL][L_SB];
   assign ta   = rd_rem_ff[RL][L_TA];
   assign tb   = rd_rem_ff[RL][L_TB];
   assign pc_r = rd_rem_ff[RL][L_PC];

   always_comb begin
      wr_a  = 1'b0;
      wr_b  = 1'b0;
      a_src = sa;
      b_src = sb;
      unique case (rd_mod_ff[RL]) inside
         rma_pkg::MOD_A: begin
            wr_a = 1'b1;
         end
         rma_pkg::MOD_B: begin
            wr_b = 1'b1;
         end
         rma_pkg::MOD_AB: begin
            wr_b  = 1'b1;
            b_src = sa;
         end
         rma_pkg::MOD_BA: begin
            wr_a  = 1'b1;
            a_src = sb;
         end
         rma_pkg::MOD_F, rma_pkg::MOD_I: begin
            wr_a = 1'b1;
            wr_b = 1'b1;
         end
         rma_pkg::MOD_X: begin
            wr_a  = 1'b1;
            wr_b  = 1'b1;
            a_src = sb;
            b_src = sa;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cp_x_in[0] = lane_value(rd_op_ff[RL], wr_a, ta, a_src, modulus_ff);
      cp_x_in[1] = lane_value(rd_op_ff[RL], wr_b, tb, b_src, modulus_ff);
      pc_inc     = {1'b0, pc_r} + (CW + 1)'(1);
      cp_pc_in   = (pc_inc == {1'b0, modulus_ff}) ? '0 : pc_inc[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_vld_ff <= 1'b0;
      end else if (adv) begin
         cp_vld_ff <= rd_vld_ff[RL];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_x_ff[0] <= cp_x_in[0];
         cp_x_ff[1] <= cp_x_in[1];
         cp_pc_ff   <= cp_pc_in;
      end
   end

   // ------------------------------------------------------ result reduction
   logic          pr_vld_ff  [PW];
   logic [CW-1:0] pr_pc_ff   [PW];
   logic [CW-1:0] pr_rem_ff  [PW][2];
   logic [PW-1:0] pr_bits_ff [PW][2];

   for (genvar k = 0; k < PW; k++) begin : g_pr
      logic          vld_src;
      logic [CW-1:0] pc_src;
      logic [CW-1:0] rem_src  [2];
      logic [PW-1:0] bits_src [2];
      logic [CW-1:0] rem_in   [2];
      logic [PW-1:0] bits_in  [2];

      if (k == 0) begin : g_head
         always_comb begin
            vld_src = cp_vld_ff;
            pc_src  = cp_pc_ff;
            for (int l = 0; l < 2; l++) begin
               rem_src[l]  = '0;
               bits_src[l] = cp_x_ff[l];
            end
         end
      end else begin : g_body
         always_comb begin
            vld_src = pr_vld_ff[k-1];
            pc_src  = pr_pc_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               rem_src[l]  = pr_rem_ff[k-1][l];
               bits_src[l] = pr_bits_ff[k-1][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rem_in[l]  = rma_pkg::mod_step(rem_src[l], bits_src[l][PW-1], modulus_ff);
            bits_in[l] = bits_src[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pr_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            pr_vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pr_pc_ff[k] <= pc_src;
            for (int l = 0; l < 2; l++) begin
               pr_rem_ff[k][l]  <= rem_in[l];
               pr_bits_ff[k][l] <= bits_in[l];
            end
         end
      end
   end

   // ---------------------------------------------------------- output buffer
   out_item_type   ob_mem_ff [OD];
   out_item_type   ob_item;
   logic [OPW-1:0] ob_wr_ptr_ff, ob_wr_ptr_in;
   logic [OPW-1:0] ob_rd_ptr_ff, ob_rd_ptr_in;
   logic           push, pop;

   assign push = adv && pr_vld_ff[PL];
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      ob_item.new_a = FIELD_WIDTH'(pr_rem_ff[PL][0]);
      ob_item.new_b = FIELD_WIDTH'(pr_rem_ff[PL][1]);
      ob_item.npc   = FIELD_WIDTH'(pr_pc_ff[PL]);
      ob_wr_ptr_in  = ob_wr_ptr_ff;
      ob_rd_ptr_in  = ob_rd_ptr_ff;
      if (push) begin
         ob_wr_ptr_in = (ob_wr_ptr_ff == OPW'(OD - 1)) ? '0 : ob_wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         ob_rd_ptr_in = (ob_rd_ptr_ff == OPW'(OD - 1)) ? '0 : ob_rd_ptr_ff + 1'b1;
      end
      ob_count_in = ob_count_ff + OCW'(push) - OCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_wr_ptr_ff <= '0;
         ob_rd_ptr_ff <= '0;
         ob_count_ff  <= '0;
      end else begin
         ob_wr_ptr_ff <= ob_wr_ptr_in;
         ob_rd_ptr_ff <= ob_rd_ptr_in;
         ob_count_ff  <= ob_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ob_mem_ff[ob_wr_ptr_ff] <= ob_item;
      end
   end

   assign rsp_ch.valid       = (ob_count_ff != '0);
   assign rsp_ch.new_a_field = ob_mem_ff[ob_rd_ptr_ff].new_a;
   assign rsp_ch.new_b_field = ob_mem_ff[ob_rd_ptr_ff].new_b;
   assign rsp_ch.next_pc     = ob_mem_ff[ob_rd_ptr_ff].npc;

   // ------------------------------------------------------------- assertions
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff[RL] |-> (sa < modulus_ff) && (sb < modulus_ff) && (ta < modulus_ff)
                        && (tb < modulus_ff) && (pc_r < modulus_ff))
      else $error("operand reduction out of range");

   a_results_reduced: assert property (@(posedge clock) disable iff (reset)
      pr_vld_ff[PL] |-> (pr_rem_ff[PL][0] < modulus_ff) && (pr_rem_ff[PL][1] < modulus_ff)
                        && (pr_pc_ff[PL] < modulus_ff))
      else $error("result reduction out of range");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      ob_count_ff <= OCW'(OD))
      else $error("output buffer overflow");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cp_vld_ff) && $stable(cp_x_ff[0]) && $stable(cp_x_ff[1])
               && $stable(pr_vld_ff[PL]))
      else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Redcode add/sub/mul unit. A table of directed
// items runs first at the reset core size, then random items run under
// several core sizes, from the extremes to random values. Every result is
// compared in order with a table value or in-bench prediction while both
// channels idle and stall at random and the result side holds off at length.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int FW = rma_pkg::CORE_WIDTH;
   localparam logic [1:0] OP_NONE  = 2'd3;
   localparam logic [2:0] MOD_NONE = 3'd7;
   localparam int N_DIR = 19;
   localparam int N_PHASE = 10;
   localparam int PHASE_ITEMS = 95;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]    op;
      logic [2:0]    mod;
      logic [FW-1:0] sa;
      logic [FW-1:0] sb;
      logic [FW-1:0] ta;
      logic [FW-1:0] tb;
      logic [FW-1:0] pc;
   } arith_req_type;

   typedef struct packed {
      logic [FW-1:0] na;
      logic [FW-1:0] nb;
      logic [FW-1:0] npc;
   } field_rsp_type;

   typedef struct packed {
      arith_req_type req;
      logic          typed;
      field_rsp_type want;
   } dir_row_type;

   // typed rows hold at the reset core size of 8000
   dir_row_type dir_rows [N_DIR] = '{
      '{'{rma_pkg::OP_ADD, rma_pkg::MOD_A, 1, 0, 2, 3, 7999}, 1'b1, '{3, 3, 0}},
      '{'{rma_pkg::OP_SUB, rma_pkg::MOD_B, 0, 5, 0, 3, 0}, 1'b1, '{0, 7998, 1}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_AB, 100, 9, 1, 100, 10}, 1'b1, '{1, 2000, 11}},
      '{'{rma_pkg::OP_ADD, rma_pkg::MOD_BA, 9, 7999, 1, 4, 20}, 1'b1, '{0, 4, 21}},
      '{'{rma_pkg::OP_SUB, rma_pkg::MOD_F, 1, 2, 0, 0, 5}, 1'b1, '{7999, 7998, 6}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_I, 3, 4, 5, 6, 6}, 1'b1, '{15, 24, 7}},
      '{'{rma_pkg::OP_ADD, rma_pkg::MOD_X, 1, 2, 10, 20, 7}, 1'b1, '{12, 21, 8}},
      '{'{OP_NONE, rma_pkg::MOD_F, 1, 2, 10, 20, 8}, 1'b1, '{10, 20, 9}},
      '{'{rma_pkg::OP_ADD, MOD_NONE, 1, 2, 10, 20, 9}, 1'b1, '{10, 20, 10}},
      '{'{rma_pkg::OP_SUB, MOD_NONE, 5, 6, 1, 2, 9}, 1'b1, '{1, 2, 10}},
      '{'{rma_pkg::OP_ADD, rma_pkg::MOD_F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{3070, 3070, 1536}},
      '{'{rma_pkg::OP_SUB, rma_pkg::MOD_X, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b1, '{0, 0, 1536}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_F, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_X, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        1'b0, '{0, 0, 0}},
      '{'{rma_pkg::OP_SUB, rma_pkg::MOD_A, 7999, 0, 0, 65534, 65534}, 1'b0, '{0, 0, 0}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_B, 0, 7999, 3, 7999, 8000}, 1'b0, '{0, 0, 0}},
      '{'{rma_pkg::OP_ADD, rma_pkg::MOD_AB, 8000, 1, 8001, 7999, 8001}, 1'b0, '{0, 0, 0}},
      '{'{rma_pkg::OP_SUB, rma_pkg::MOD_BA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA},
        1'b0, '{0, 0, 0}},
      '{'{rma_pkg::OP_MUL, rma_pkg::MOD_I, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555},
        1'b0, '{0, 0, 0}}
   };

   logic clock;
   logic reset;

   rma_req_if #(.FIELD_WIDTH(FW)) req_ch ();
   rma_rsp_if #(.FIELD_WIDTH(FW)) rsp_ch ();
   rma_csr_if csr_ch ();

   redcode_modular_arith_unit_top #(.FIELD_WIDTH(FW)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   field_rsp_type pending_fields [$];
   logic [FW-1:0] core_size_now;
   int            error_count;
   int            send_idle_pct;
   int            stall_pct;
   bit            hold_start;
   bit            hold_done;
   int            hold_left;
   field_rsp_type got_rsp;
   field_rsp_type want_rsp;

   function automatic longint unsigned apply_field_op(
      logic [1:0] op, longint unsigned t, longint unsigned s, longint unsigned m
   );
      case (op)
         rma_pkg::OP_ADD: return (t + s) % m;
         rma_pkg::OP_SUB: return (t + m - s) % m;
         rma_pkg::OP_MUL: return (t * s) % m;
         default:         return t;
      endcase
   endfunction

   function automatic field_rsp_type predict_fields(arith_req_type r, logic [FW-1:0] cs);
      longint unsigned m, sa, sb, ta, tb, na, nb;
      field_rsp_type p;
      m  = (cs == 0) ? 1 : cs;
      sa = r.sa % m;
      sb = r.sb % m;
      ta = r.ta % m;
      tb = r.tb % m;
      na = ta;
      nb = tb;
      case (r.mod) inside
         rma_pkg::MOD_A:  na = apply_field_op(r.op, ta, sa, m);
         rma_pkg::MOD_B:  nb = apply_field_op(r.op, tb, sb, m);
         rma_pkg::MOD_AB: nb = apply_field_op(r.op, tb, sa, m);
         rma_pkg::MOD_BA: na = apply_field_op(r.op, ta, sb, m);
         rma_pkg::MOD_F, rma_pkg::MOD_I: begin
            na = apply_field_op(r.op, ta, sa, m);
            nb = apply_field_op(r.op, tb, sb, m);
         end
         rma_pkg::MOD_X: begin
            na = apply_field_op(r.op, ta, sb, m);
            nb = apply_field_op(r.op, tb, sa, m);
         end
         default: ;
      endcase
      p.na  = FW'(na);
      p.nb  = FW'(nb);
      p.npc = FW'((r.pc % m + 1) % m);
      return p;
   endfunction

   function automatic logic [FW-1:0] rand_field(logic [FW-1:0] cs);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return cs - 1'b1;
         3:       return cs;
         4:       return cs + 1'b1;
         5:       return (cs == 0) ? '0 : FW'($urandom_range(0, cs - 1));
         default: return FW'($urandom);
      endcase
   endfunction

   function automatic arith_req_type rand_item(logic [FW-1:0] cs);
      arith_req_type r;
      r.op  = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
      r.mod = ($urandom_range(0, 15) == 0) ? MOD_NONE : 3'($urandom_range(0, 6));
      r.sa  = rand_field(cs);
      r.sb  = rand_field(cs);
      r.ta  = rand_field(cs);
      r.tb  = rand_field(cs);
      r.pc  = rand_field(cs);
      return r;
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send_item(arith_req_type r, bit typed, field_rsp_type want);
      while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.req_type    = r.op;
      req_ch.modifier    = r.mod;
      req_ch.src_a_field = r.sa;
      req_ch.src_b_field = r.sb;
      req_ch.dst_a_field = r.ta;
      req_ch.dst_b_field = r.tb;
      req_ch.pc          = r.pc;
      do @(posedge clock); while (!req_ch.ready);
      pending_fields.push_back(typed ? want : predict_fields(r, core_size_now));
      @(negedge clock);
   endtask

   task automatic write_core_size(logic [FW-1:0] cs);
      req_ch.valid     = 1'b0;
      csr_ch.valid     = 1'b1;
      csr_ch.core_size = cs;
      do @(posedge clock); while (!csr_ch.ready);
      core_size_now = cs;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (pending_fields.size() != 0) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb_top: FAIL");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_start && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left    = hold_left - 1;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = ($urandom_range(1, 100) > stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_rsp = '{rsp_ch.new_a_field, rsp_ch.new_b_field, rsp_ch.next_pc};
         if (pending_fields.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected result a=%0d b=%0d pc=%0d", $realtime,
                        got_rsp.na, got_rsp.nb, got_rsp.npc);
         end else begin
            want_rsp = pending_fields.pop_front();
            if (got_rsp.na !== want_rsp.na || got_rsp.nb !== want_rsp.nb ||
                got_rsp.npc !== want_rsp.npc) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: mismatch exp a=%0d b=%0d pc=%0d got a=%0d b=%0d pc=%0d",
                           $realtime, want_rsp.na, want_rsp.nb, want_rsp.npc,
                           got_rsp.na, got_rsp.nb, got_rsp.npc);
            end
         end
      end
   end

   initial begin
      logic [FW-1:0] core_list [N_PHASE];
      arith_req_type r;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = '0;
      req_ch.modifier    = '0;
      req_ch.src_a_field = '0;
      req_ch.src_b_field = '0;
      req_ch.dst_a_field = '0;
      req_ch.dst_b_field = '0;
      req_ch.pc          = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.core_size   = '0;
      core_size_now      = rma_pkg::CORE_SIZE_RESET;
      send_idle_pct      = 0;
      stall_pct          = 0;
      core_list = '{16'd65535, 16'd2, 16'd0, 16'd1, 16'd7, FW'($urandom_range(2, 65535)),
                    rma_pkg::CORE_SIZE_RESET, 16'd65534, 16'd3,
                    FW'($urandom_range(2, 400))};

      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

      // long result hold-off while items keep coming, then wait for all
      hold_start = 1'b1;
      repeat (120) send_item(rand_item(core_size_now), 1'b0, '0);
      drain_results();

      for (int p = 0; p < N_PHASE; p++) begin
         write_core_size(core_list[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase
         repeat (PHASE_ITEMS) begin
            r = rand_item(core_size_now);
            send_item(r, 1'b0, '0);
         end
         drain_results();
      end

      repeat (60) @(negedge clock);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: redcode_modular_arith_unit_top.f
rtl/rma_pkg.sv
rtl/rma_if.sv
rtl/redcode_modular_arith_unit_top.sv
tb/tb_top.sv
